// ===== sv/life_automaton_generation_unit_macros.svh =====
// Assertion macros for the Life generation unit.
`ifndef LIFE_AUTOMATON_GENERATION_UNIT_MACROS_SVH
`define LIFE_AUTOMATON_GENERATION_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LIFEGEN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LIFEGEN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lifegen_pkg.sv =====
// Shared constants, types and the B3/S23 rule function for the Life generation unit.
package lifegen_pkg;

   localparam int MAX_COLS   = 1024;
   localparam int MAX_ROWS   = 1024;
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int NCOL_W     = $clog2(MAX_COLS + 1);
   localparam int NROW_W     = $clog2(MAX_ROWS + 1);
   localparam int ROW_W      = $clog2(MAX_ROWS + 2);
   localparam int CSR_DATA_W = 11;
   localparam int IDX_OUT_W  = 10;
   localparam int WIN_W      = 9;
   localparam int SURVIVE_N  = 2;
   localparam int BIRTH_N    = 3;

   typedef enum logic [0:0] {
      CSR_ROWS_IN_USE = 1'b0,
      CSR_COLS_IN_USE = 1'b1
   } csr_index_type;

   // Position and live flags of one accepted transaction.
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             bot;
      logic             mid_live;
      logic             top_live;
   } cell_pos_type;

   // Next state of the centre cell (bit 4) of a 3x3 window.
   function automatic logic next_state(input logic [WIN_W-1:0] w);
      logic [3:0] n;
      n = '0;
      for (int b = 0; b < WIN_W; b++) begin
         if (b != 4) begin
            n = n + 4'(w[b]);
         end
      end
      if (n == 4'(BIRTH_N)) begin
         return 1'b1;
      end else if (n == 4'(SURVIVE_N)) begin
         return w[4];
      end
      return 1'b0;
   endfunction

endpackage

// ===== sv/lifegen_req_if.sv =====
// Input channel: current-generation cells with valid/ready.
interface lifegen_req_if;
   logic valid;
   logic ready;
   logic cell_alive;
   logic is_pad;

   modport source (output valid, output cell_alive, output is_pad, input ready);
   modport sink   (input valid, input cell_alive, input is_pad, output ready);
endinterface

// ===== sv/lifegen_rsp_if.sv =====
// Result channel: next-generation cells with position and frame marker.
interface lifegen_rsp_if;
   import lifegen_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 next_alive;
   logic [IDX_OUT_W-1:0] row_index;
   logic [IDX_OUT_W-1:0] col_index;
   logic                 frame_last;

   modport source (output valid, output next_alive, output row_index, output col_index,
                   output frame_last, input ready);
   modport sink   (input valid, input next_alive, input row_index, input col_index,
                   input frame_last, output ready);
endinterface

// ===== sv/lifegen_linebuf.sv =====
// Two line stores packed in one synchronous RAM with same-entry forwarding.
module lifegen_linebuf (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [lifegen_pkg::COL_W-1:0] rd_addr,
   output logic [1:0]                   rd_data,
   input  logic                         wr_en,
   input  logic [lifegen_pkg::COL_W-1:0] wr_addr,
   input  logic [1:0]                   wr_data
);
   import lifegen_pkg::*;

   // bit 1: upper row, bit 0: middle row
   logic [1:0] line_mem_ff [MAX_COLS];
   logic [1:0] rdata_ff;
   logic       fwd_ff;
   logic [1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff    <= line_mem_ff[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rdata_ff;

endmodule

// ===== sv/lifegen_window.sv =====
// Window stage: 3x3 neighbourhood, B3/S23 rule and the output register.
module lifegen_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  lifegen_pkg::cell_pos_type         in_pos,
   output logic                              in_ready,
   input  logic [1:0]                        mem_rd,
   output logic                              wr_en,
   output logic [lifegen_pkg::COL_W-1:0]     wr_addr,
   output logic [1:0]                        wr_data,
   input  logic [lifegen_pkg::NROW_W-1:0]    nrows,
   input  logic [lifegen_pkg::NCOL_W-1:0]    ncols,
   lifegen_rsp_if.source                     rsp_ch
);
   import lifegen_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   cell_pos_type         s1_pos_ff;
   logic [WIN_W-1:0]     window_ff, window_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_alive_ff;
   logic [IDX_OUT_W-1:0] out_row_ff;
   logic [IDX_OUT_W-1:0] out_col_ff;
   logic                 out_last_ff;

   logic [2:0]           slice;
   logic [WIN_W-1:0]     eval_win;
   logic                 emit;
   logic                 alive;
   logic [ROW_W-1:0]     crow;
   logic [COL_W-1:0]     ccol;
   logic                 last;
   logic                 s1_adv;
   logic                 out_load;

   always_comb begin
      slice = {s1_pos_ff.bot,
               s1_pos_ff.mid_live & mem_rd[0],
               s1_pos_ff.top_live & mem_rd[1]};
      if (s1_pos_ff.col == '0) begin
         // close the last column of the row two behind
         eval_win  = {3'b000, window_ff[WIN_W-1:3]};
         window_in = {slice, 6'b000000};
         emit      = s1_pos_ff.row >= ROW_W'(2);
         crow      = s1_pos_ff.row - ROW_W'(2);
         ccol      = COL_W'(ncols - NCOL_W'(1));
      end else begin
         eval_win  = {slice, window_ff[WIN_W-1:3]};
         window_in = eval_win;
         emit      = s1_pos_ff.row != '0;
         crow      = s1_pos_ff.row - ROW_W'(1);
         ccol      = s1_pos_ff.col - COL_W'(1);
      end
      alive = next_state(eval_win);
      last  = (crow == ROW_W'(nrows) - ROW_W'(1)) &&
              (ccol == COL_W'(ncols - NCOL_W'(1)));
   end

   assign s1_adv   = s1_valid_ff && (!emit || !out_valid_ff || rsp_ch.ready);
   assign out_load = s1_adv && emit;
   assign in_ready = !s1_valid_ff || s1_adv;

   assign wr_en   = s1_adv;
   assign wr_addr = s1_pos_ff.col;
   assign wr_data = {mem_rd[0], s1_pos_ff.bot};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (in_valid) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_pos_ff <= in_pos;
      end
      if (s1_adv) begin
         window_ff <= window_in;
      end
      if (out_load) begin
         out_alive_ff <= alive;
         out_row_ff   <= IDX_OUT_W'(crow);
         out_col_ff   <= IDX_OUT_W'(ccol);
         out_last_ff  <= last;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.next_alive = out_alive_ff;
   assign rsp_ch.row_index  = out_row_ff;
   assign rsp_ch.col_index  = out_col_ff;
   assign rsp_ch.frame_last = out_last_ff;

endmodule

// ===== sv/life_automaton_generation_unit.sv =====
// Top level of the Life generation unit: raster counters, registers and line stores.
// One cell transaction is taken per clock unless the result channel stalls; each result
// follows its cell by one row plus one cell of input, then the read stage and the output
// register. That rate is set by the single line-store RAM, read at the incoming cell's
// column and written at the previous cell's, forwarding when consecutive transactions hit
// one entry. The line stores need no clearing pass after reset. After each frame send
// cols_in_use+1 pad transactions to flush the last row; a register write restarts the frame.
`include "life_automaton_generation_unit_macros.svh"

module life_automaton_generation_unit (
   input  logic                                clock,
   input  logic                                reset,
   lifegen_req_if.sink                         req_ch,
   lifegen_rsp_if.source                       rsp_ch,
   input  logic                                csr_we,
   input  lifegen_pkg::csr_index_type          csr_index,
   input  logic [lifegen_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lifegen_pkg::*;

   logic [NROW_W-1:0] nrows_ff, nrows_in;
   logic [NCOL_W-1:0] ncols_ff, ncols_in;
   logic [ROW_W-1:0]  ir_ff, ir_in;
   logic [COL_W-1:0]  ic_ff, ic_in;

   logic              accept;
   logic              restart;
   logic [ROW_W-1:0]  ir_eff;
   logic [COL_W-1:0]  ic_eff;
   logic [ROW_W-1:0]  nrows_x;
   cell_pos_type      pos;
   logic              win_ready;
   logic [1:0]        mem_rd;
   logic              wr_en;
   logic [COL_W-1:0]  wr_addr;
   logic [1:0]        wr_data;

   assign accept  = req_ch.valid && win_ready;
   assign req_ch.ready = win_ready;
   assign nrows_x = ROW_W'(nrows_ff);

   always_comb begin
      restart = (NCOL_W'(ic_ff) >= ncols_ff) || (ir_ff > nrows_x + ROW_W'(1));
      ir_eff  = restart ? '0 : ir_ff;
      ic_eff  = restart ? '0 : ic_ff;

      pos.row      = ir_eff;
      pos.col      = ic_eff;
      pos.bot      = (ir_eff < nrows_x) && !req_ch.is_pad && req_ch.cell_alive;
      pos.mid_live = (ir_eff != '0) && (ir_eff <= nrows_x);
      pos.top_live = (ir_eff >= ROW_W'(2)) && (ir_eff <= nrows_x + ROW_W'(1));
   end

   always_comb begin
      nrows_in = nrows_ff;
      ncols_in = ncols_ff;
      ir_in    = ir_ff;
      ic_in    = ic_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS_IN_USE: begin
               if (csr_wdata == '0) begin
                  nrows_in = NROW_W'(1);
               end else if (int'(csr_wdata) > MAX_ROWS) begin
                  nrows_in = NROW_W'(MAX_ROWS);
               end else begin
                  nrows_in = NROW_W'(csr_wdata);
               end
            end
            CSR_COLS_IN_USE: begin
               if (csr_wdata == '0) begin
                  ncols_in = NCOL_W'(1);
               end else if (int'(csr_wdata) > MAX_COLS) begin
                  ncols_in = NCOL_W'(MAX_COLS);
               end else begin
                  ncols_in = NCOL_W'(csr_wdata);
               end
            end
            default: begin
            end
         endcase
         ir_in = '0;
         ic_in = '0;
      end else if (accept) begin
         if (ir_eff >= nrows_x + ROW_W'(1)) begin
            ir_in = '0;
            ic_in = '0;
         end else if (NCOL_W'(ic_eff) + NCOL_W'(1) >= ncols_ff) begin
            ir_in = ir_eff + ROW_W'(1);
            ic_in = '0;
         end else begin
            ir_in = ir_eff;
            ic_in = ic_eff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nrows_ff <= NROW_W'(MAX_ROWS);
         ncols_ff <= NCOL_W'(MAX_COLS);
         ir_ff    <= '0;
         ic_ff    <= '0;
      end else begin
         nrows_ff <= nrows_in;
         ncols_ff <= ncols_in;
         ir_ff    <= ir_in;
         ic_ff    <= ic_in;
      end
   end

   lifegen_linebuf u_linebuf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (ic_eff),
      .rd_data (mem_rd),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   lifegen_window u_window (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_pos   (pos),
      .in_ready (win_ready),
      .mem_rd   (mem_rd),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .nrows    (nrows_ff),
      .ncols    (ncols_ff),
      .rsp_ch   (rsp_ch)
   );

   `LIFEGEN_ASSERT_NOW(a_col_in_range, clock, reset, 1'b1, NCOL_W'(ic_ff) < ncols_ff, "column counter beyond row width")
   `LIFEGEN_ASSERT_NOW(a_row_in_range, clock, reset, 1'b1, ir_ff <= nrows_x + ROW_W'(1), "row counter beyond flush row")
   `LIFEGEN_ASSERT_NOW(a_last_col, clock, reset, rsp_ch.valid && rsp_ch.frame_last, rsp_ch.col_index == IDX_OUT_W'(ncols_ff - NCOL_W'(1)), "frame end not on last column")
   `LIFEGEN_ASSERT_NEXT(a_csr_restart, clock, reset, csr_we, (ir_ff == '0) && (ic_ff == '0), "register write did not restart frame")

endmodule
